>>> hdl/fbns_pkg.sv
package fbns_pkg;

  localparam int STORE_DEPTH = 16384;
  localparam int ADDR_W      = 14;
  localparam int VAL_W       = 16;
  localparam int SUM_W       = 20;
  localparam int OCT_W       = 5;   // octave_count register
  localparam int OCT_CNT_W   = 6;   // holds MAX_OCTAVES up to 32
  localparam int IN_DATA_W   = 96;
  localparam int OUT_DATA_W  = 24;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // register index as seen on paddr[2]
  localparam logic REG_OCTAVE_COUNT = 1'b0;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REDUCE = 5'b00010,
    ST_RUN    = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;      // capture coordinates, clear sum
    logic wr;        // store one table entry
    logic reduce;    // one step of the initial cell reduction
    logic issue;     // start one octave
    logic out_load;  // move sum into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } dp_stat_t;

endpackage

>>> hdl/fractal_bilinear_noise_sampler.sv
// Channel  Dir  Handshake            Payload
// in_      in   in_tvalid/in_tready  tuser: cmd; tdata: index, value, coord_u, coord_v
// out_     out  out_tvalid/out_tready tdata: height_sum
// cfg_     in   APB write/read       octave_count at byte address 0
//
// A table write is accepted while idle. A sample runs the cell reduction four coordinate
// bits per cycle, then one octave issues per cycle (two table copies, two read ports
// each), then a 4-stage interpolation pipe drains. Synchronous active-low reset clears
// control only; the table is undefined until written. A result waiting in the output
// register does not block the next input transfer.
module fractal_bilinear_noise_sampler #(
  parameter int TABLE_SIDE  = 32,
  parameter int FRAC_BITS   = 12,
  parameter int MAX_OCTAVES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [13:0] table_index, [29:14] table_value, [61:30] coord_u, [93:62] coord_v
  input  logic [fbns_pkg::IN_DATA_W-1:0]     in_tdata,
  // [0] cmd
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [19:0] height_sum
  output logic [fbns_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [fbns_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [fbns_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [fbns_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  logic [fbns_pkg::OCT_W-1:0]         octave_count_r;
  fbns_pkg::dp_cmd_t                  cmd;
  fbns_pkg::dp_stat_t                 stat;
  logic signed [fbns_pkg::SUM_W-1:0]  height_sum;
  logic                               is_sample;

  assign cfg_pready = 1'b1;
  assign is_sample  = (in_tuser == fbns_pkg::CMD_SAMPLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_count_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr[2] == fbns_pkg::REG_OCTAVE_COUNT) begin
      octave_count_r <= cfg_pwdata[fbns_pkg::OCT_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == fbns_pkg::REG_OCTAVE_COUNT)
                    ? fbns_pkg::CFG_DATA_W'(octave_count_r) : '0;

  fbns_ctrl #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_OCTAVES(MAX_OCTAVES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_is_sample(is_sample),
    .in_ready    (in_tready),
    .octave_count(octave_count_r),
    .cmd         (cmd),
    .stat        (stat)
  );

  fbns_dp #(
    .TABLE_SIDE(TABLE_SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .wr_index (in_tdata[13:0]),
    .wr_value (signed'(in_tdata[29:14])),
    .coord_u  (signed'(in_tdata[61:30])),
    .coord_v  (signed'(in_tdata[93:62])),
    .out_ready(out_tready),
    .out_valid(out_tvalid),
    .out_sum  (height_sum)
  );

  assign out_tdata = {{(fbns_pkg::OUT_DATA_W - fbns_pkg::SUM_W){1'b0}}, height_sum};

endmodule

>>> hdl/fbns_ctrl.sv
module fbns_ctrl #(
  parameter int FRAC_BITS   = 12,
  parameter int MAX_OCTAVES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_is_sample,
  output logic                          in_ready,
  input  logic [fbns_pkg::OCT_W-1:0]    octave_count,
  output fbns_pkg::dp_cmd_t             cmd,
  input  fbns_pkg::dp_stat_t            stat
);

  localparam int XW  = 32 - FRAC_BITS;
  localparam int NCH = (XW + 3) / 4;
  localparam int RCW = $clog2(NCH + 1);
  localparam logic [fbns_pkg::OCT_CNT_W-1:0] MAX_OCT =
    fbns_pkg::OCT_CNT_W'(MAX_OCTAVES);
  localparam logic [RCW-1:0] RED_LAST = RCW'(NCH - 1);

  fbns_pkg::state_t                  state_r, state_nxt;
  logic [RCW-1:0]                    red_cnt_r, red_cnt_nxt;
  logic [fbns_pkg::OCT_CNT_W-1:0]    oct_cnt_r, oct_cnt_nxt;
  logic [fbns_pkg::OCT_CNT_W-1:0]    n_r, n_nxt;
  logic [fbns_pkg::OCT_CNT_W-1:0]    n_sat;

  always_comb begin
    n_sat = fbns_pkg::OCT_CNT_W'(octave_count);
    if (n_sat > MAX_OCT) begin
      n_sat = MAX_OCT;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    red_cnt_nxt = red_cnt_r;
    oct_cnt_nxt = oct_cnt_r;
    n_nxt       = n_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      fbns_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_is_sample) begin
            cmd.load    = 1'b1;
            n_nxt       = n_sat;
            red_cnt_nxt = '0;
            // no octaves: sum stays zero
            state_nxt   = (n_sat == '0) ? fbns_pkg::ST_DONE : fbns_pkg::ST_REDUCE;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      fbns_pkg::ST_REDUCE: begin
        cmd.reduce  = 1'b1;
        red_cnt_nxt = red_cnt_r + 1'b1;
        if (red_cnt_r == RED_LAST) begin
          oct_cnt_nxt = '0;
          state_nxt   = fbns_pkg::ST_RUN;
        end
      end
      fbns_pkg::ST_RUN: begin
        cmd.issue   = 1'b1;
        oct_cnt_nxt = oct_cnt_r + 1'b1;
        if (oct_cnt_nxt == n_r) begin
          state_nxt = fbns_pkg::ST_DRAIN;
        end
      end
      fbns_pkg::ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = fbns_pkg::ST_DONE;
        end
      end
      fbns_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = fbns_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fbns_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= fbns_pkg::ST_IDLE;
      red_cnt_r <= '0;
      oct_cnt_r <= '0;
      n_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      red_cnt_r <= red_cnt_nxt;
      oct_cnt_r <= oct_cnt_nxt;
      n_r       <= n_nxt;
    end
  end

endmodule

>>> hdl/fbns_dp.sv
module fbns_dp #(
  parameter int TABLE_SIDE = 32,
  parameter int FRAC_BITS  = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fbns_pkg::dp_cmd_t                   cmd,
  output fbns_pkg::dp_stat_t                  stat,
  input  logic [fbns_pkg::ADDR_W-1:0]         wr_index,
  input  logic signed [fbns_pkg::VAL_W-1:0]   wr_value,
  input  logic signed [31:0]                  coord_u,
  input  logic signed [31:0]                  coord_v,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [fbns_pkg::SUM_W-1:0]   out_sum
);

  localparam int CW    = (TABLE_SIDE > 1) ? $clog2(TABLE_SIDE) : 1;
  localparam int CW1   = CW + 1;
  localparam int XW    = 32 - FRAC_BITS;
  localparam int NCH   = (XW + 3) / 4;
  localparam int RW    = NCH * 4;
  localparam int KMOD  = int'((64'd1 << XW) % TABLE_SIDE);
  localparam int PW    = FRAC_BITS + 18;
  localparam int FAW   = 18;
  localparam int TILE  = (TABLE_SIDE * TABLE_SIDE) % fbns_pkg::STORE_DEPTH;
  localparam logic [CW1-1:0] SIDE_E = CW1'(TABLE_SIDE);
  localparam logic [CW1-1:0] K_E    = CW1'(KMOD);
  localparam logic [CW-1:0]  SIDE_M1 = CW'(TABLE_SIDE - 1);
  localparam logic [fbns_pkg::ADDR_W-1:0] TILE_STEP = fbns_pkg::ADDR_W'(TILE);

  // (2m + b) mod side, with m already reduced
  function automatic logic [CW-1:0] mod_dbl(input logic [CW-1:0] m, input logic b);
    logic [CW1-1:0] t;
    t = {m, b};
    if (t >= SIDE_E) begin
      t = t - SIDE_E;
    end
    return t[CW-1:0];
  endfunction

  // takes out the weight of the sign bit of the cell field
  function automatic logic [CW-1:0] cell_fix(input logic [CW-1:0] m, input logic msb);
    logic [CW1-1:0] t;
    t = {1'b0, m};
    if (msb) begin
      if (t >= K_E) begin
        t = t - K_E;
      end else begin
        t = t + SIDE_E - K_E;
      end
    end
    return t[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] red4(input logic [CW-1:0] m, input logic [3:0] bits);
    logic [CW-1:0] t;
    t = m;
    for (int i = 3; i >= 0; i--) begin
      t = mod_dbl(t, bits[i]);
    end
    return t;
  endfunction

  function automatic logic [CW-1:0] cell_inc(input logic [CW-1:0] c);
    return (c == SIDE_M1) ? '0 : c + 1'b1;
  endfunction

  function automatic logic [fbns_pkg::ADDR_W-1:0] tab_addr(
    input logic [fbns_pkg::ADDR_W-1:0] base,
    input logic [CW-1:0] row,
    input logic [CW-1:0] col
  );
    logic [FAW-1:0] full;
    full = FAW'(base) + FAW'(row) * FAW'(TABLE_SIDE) + FAW'(col);
    return full[fbns_pkg::ADDR_W-1:0];
  endfunction

  // two copies of the table, each read at two addresses per cycle
  logic signed [fbns_pkg::VAL_W-1:0] mem_a [fbns_pkg::STORE_DEPTH];
  logic signed [fbns_pkg::VAL_W-1:0] mem_b [fbns_pkg::STORE_DEPTH];

  logic signed [31:0]               u_r, v_r;
  logic [CW-1:0]                    mu_r, mv_r;
  logic [RW-1:0]                    redu_r, redv_r;
  logic [fbns_pkg::ADDR_W-1:0]      base_r;

  logic [CW-1:0]                    c0, c1, r0, r1;
  logic [fbns_pkg::ADDR_W-1:0]      a00, a01, a10, a11;

  logic                             v1_r, v2_r, v3_r, v4_r;
  logic signed [fbns_pkg::VAL_W-1:0] d00_r, d01_r, d10_r, d11_r;
  logic [FRAC_BITS-1:0]             fu1_r, fv1_r, fv2_r, fv3_r;
  logic signed [PW-1:0]             pt2_r, pb2_r, pv4_r;
  logic signed [fbns_pkg::VAL_W-1:0] a2_r, c2_r, top3_r, bot3_r, top4_r;
  logic signed [fbns_pkg::SUM_W-1:0] sum_r;
  logic                             out_valid_r;
  logic signed [fbns_pkg::SUM_W-1:0] out_sum_r;

  logic signed [16:0]               dt, db, dv;
  logic signed [PW-1:0]             pt_nxt, pb_nxt, pv_nxt;
  logic signed [fbns_pkg::VAL_W-1:0] top_nxt, bot_nxt, oct_val;

  assign c0  = cell_fix(mu_r, u_r[31]);
  assign r0  = cell_fix(mv_r, v_r[31]);
  assign c1  = cell_inc(c0);
  assign r1  = cell_inc(r0);
  assign a00 = tab_addr(base_r, r0, c0);
  assign a01 = tab_addr(base_r, r0, c1);
  assign a10 = tab_addr(base_r, r1, c0);
  assign a11 = tab_addr(base_r, r1, c1);

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem_a[wr_index] <= wr_value;
    end
    if (cmd.issue) begin
      d00_r <= mem_a[a00];
      d01_r <= mem_a[a01];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem_b[wr_index] <= wr_value;
    end
    if (cmd.issue) begin
      d10_r <= mem_b[a10];
      d11_r <= mem_b[a11];
    end
  end

  // coordinate state: cell field kept reduced mod side, doubled each octave
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      u_r    <= coord_u;
      v_r    <= coord_v;
      mu_r   <= '0;
      mv_r   <= '0;
      redu_r <= RW'(coord_u[31:FRAC_BITS]);
      redv_r <= RW'(coord_v[31:FRAC_BITS]);
      base_r <= '0;
    end else if (cmd.reduce) begin
      mu_r   <= red4(mu_r, redu_r[RW-1 -: 4]);
      mv_r   <= red4(mv_r, redv_r[RW-1 -: 4]);
      redu_r <= redu_r << 4;
      redv_r <= redv_r << 4;
    end else if (cmd.issue) begin
      mu_r   <= cell_fix(mod_dbl(mu_r, u_r[FRAC_BITS-1]), u_r[31]);
      mv_r   <= cell_fix(mod_dbl(mv_r, v_r[FRAC_BITS-1]), v_r[31]);
      u_r    <= u_r <<< 1;
      v_r    <= v_r <<< 1;
      base_r <= base_r + TILE_STEP;
    end
  end

  // interpolation pipeline; a + f*(b-a)/2^F equals the weighted sum, floored
  always_comb begin
    dt      = 17'(d01_r) - 17'(d00_r);
    db      = 17'(d11_r) - 17'(d10_r);
    pt_nxt  = PW'(signed'({1'b0, fu1_r})) * PW'(dt);
    pb_nxt  = PW'(signed'({1'b0, fu1_r})) * PW'(db);
    top_nxt = 16'(17'(a2_r) + 17'(pt2_r >>> FRAC_BITS));
    bot_nxt = 16'(17'(c2_r) + 17'(pb2_r >>> FRAC_BITS));
    dv      = 17'(bot3_r) - 17'(top3_r);
    pv_nxt  = PW'(signed'({1'b0, fv3_r})) * PW'(dv);
    oct_val = 16'(17'(top4_r) + 17'(pv4_r >>> FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      fu1_r <= u_r[FRAC_BITS-1:0];
      fv1_r <= v_r[FRAC_BITS-1:0];
    end
    pt2_r  <= pt_nxt;
    pb2_r  <= pb_nxt;
    a2_r   <= d00_r;
    c2_r   <= d10_r;
    fv2_r  <= fv1_r;
    top3_r <= top_nxt;
    bot3_r <= bot_nxt;
    fv3_r  <= fv2_r;
    pv4_r  <= pv_nxt;
    top4_r <= top3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sum_r <= '0;
    end else if (v4_r) begin
      sum_r <= sum_r + fbns_pkg::SUM_W'(oct_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sum_r <= sum_r;
    end
  end

  assign stat.pipe_busy = v1_r | v2_r | v3_r | v4_r;
  assign stat.out_free  = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_sum        = out_sum_r;

endmodule
